>>> src/apbc_pkg.sv
// package for the airbrake apogee controller: types, constants and control program
package apbc_pkg;

  localparam int unsigned PC_W = 4;

  localparam logic [16:0] LEVEL_ONE = 17'd65536;

  localparam logic [2:0] REG_TARGET_ALT    = 3'd0;
  localparam logic [2:0] REG_GAIN          = 3'd1;
  localparam logic [2:0] REG_DEADBAND      = 3'd2;
  localparam logic [2:0] REG_MAX_STEP      = 3'd3;
  localparam logic [2:0] REG_MAX_ANGLE     = 3'd4;
  localparam logic [2:0] REG_UPDATE_PERIOD = 3'd5;

  localparam logic [1:0] PHASE_COAST   = 2'd1;
  localparam logic [1:0] PHASE_DESCENT = 2'd2;

  localparam logic FUNC_START = 1'b0;

  // program addresses
  localparam logic [PC_W-1:0] PC_FETCH    = 4'd0;
  localparam logic [PC_W-1:0] PC_DISPATCH = 4'd1;
  localparam logic [PC_W-1:0] PC_GATE     = 4'd2;
  localparam logic [PC_W-1:0] PC_TAKE     = 4'd3;
  localparam logic [PC_W-1:0] PC_MUL      = 4'd4;
  localparam logic [PC_W-1:0] PC_DBAND    = 4'd5;
  localparam logic [PC_W-1:0] PC_CLAMP    = 4'd6;
  localparam logic [PC_W-1:0] PC_ANGLE    = 4'd7;
  localparam logic [PC_W-1:0] PC_EMIT     = 4'd8;
  localparam logic [PC_W-1:0] PC_RET      = 4'd9;
  localparam logic [PC_W-1:0] PC_START    = 4'd10;
  localparam logic [PC_W-1:0] PC_DESC     = 4'd11;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_TAKE,
    OP_MUL,
    OP_CLAMP,
    OP_ANGLE,
    OP_EMIT,
    OP_START,
    OP_DESC
  } apbc_op_t;

  typedef enum logic [3:0] {
    CND_NONE,
    CND_ALWAYS,
    CND_NOACC,
    CND_START,
    CND_SKIP,
    CND_DESC,
    CND_NOCOAST,
    CND_DBAND,
    CND_BUSY
  } apbc_cnd_t;

  typedef struct packed {
    logic            fetch;
    apbc_op_t        op;
    apbc_cnd_t       cnd;
    logic [PC_W-1:0] tgt;
  } apbc_cw_t;

  typedef struct packed {
    logic noacc;
    logic start;
    logic skip;
    logic desc;
    logic nocoast;
    logic dband;
    logic busy;
  } apbc_flags_t;

  function automatic apbc_cw_t apbc_rom(input logic [PC_W-1:0] pc);
    apbc_cw_t cw;
    cw = '{fetch: 1'b0, op: OP_NONE, cnd: CND_NONE, tgt: PC_FETCH};
    case (pc)
      PC_FETCH:    cw = '{fetch: 1'b1, op: OP_NONE,  cnd: CND_NOACC,   tgt: PC_FETCH};
      PC_DISPATCH: cw = '{fetch: 1'b0, op: OP_NONE,  cnd: CND_START,   tgt: PC_START};
      PC_GATE:     cw = '{fetch: 1'b0, op: OP_NONE,  cnd: CND_SKIP,    tgt: PC_FETCH};
      PC_TAKE:     cw = '{fetch: 1'b0, op: OP_TAKE,  cnd: CND_DESC,    tgt: PC_DESC};
      PC_MUL:      cw = '{fetch: 1'b0, op: OP_MUL,   cnd: CND_NOCOAST, tgt: PC_FETCH};
      PC_DBAND:    cw = '{fetch: 1'b0, op: OP_NONE,  cnd: CND_DBAND,   tgt: PC_ANGLE};
      PC_CLAMP:    cw = '{fetch: 1'b0, op: OP_CLAMP, cnd: CND_NONE,    tgt: PC_FETCH};
      PC_ANGLE:    cw = '{fetch: 1'b0, op: OP_ANGLE, cnd: CND_NONE,    tgt: PC_FETCH};
      PC_EMIT:     cw = '{fetch: 1'b0, op: OP_EMIT,  cnd: CND_BUSY,    tgt: PC_EMIT};
      PC_RET:      cw = '{fetch: 1'b0, op: OP_NONE,  cnd: CND_ALWAYS,  tgt: PC_FETCH};
      PC_START:    cw = '{fetch: 1'b0, op: OP_START, cnd: CND_ALWAYS,  tgt: PC_ANGLE};
      PC_DESC:     cw = '{fetch: 1'b0, op: OP_DESC,  cnd: CND_ALWAYS,  tgt: PC_ANGLE};
      default:     cw = '{fetch: 1'b0, op: OP_NONE,  cnd: CND_ALWAYS,  tgt: PC_FETCH};
    endcase
    return cw;
  endfunction

endpackage

>>> src/apbc_seq.sv
// control sequencer: step counter, program table and conditional jumps
module apbc_seq (
  input  logic                 clk,
  input  logic                 rst_n,
  input  apbc_pkg::apbc_flags_t flags,
  output apbc_pkg::apbc_cw_t    cw
);
  import apbc_pkg::*;

  logic [PC_W-1:0] pc_r;
  logic [PC_W-1:0] pc_nxt;
  logic            take;

  assign cw = apbc_rom(pc_r);

  always_comb begin
    case (cw.cnd)
      CND_NONE:    take = 1'b0;
      CND_ALWAYS:  take = 1'b1;
      CND_NOACC:   take = flags.noacc;
      CND_START:   take = flags.start;
      CND_SKIP:    take = flags.skip;
      CND_DESC:    take = flags.desc;
      CND_NOCOAST: take = flags.nocoast;
      CND_DBAND:   take = flags.dband;
      CND_BUSY:    take = flags.busy;
      default:     take = 1'b1;
    endcase
    pc_nxt = take ? cw.tgt : pc_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= PC_FETCH;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    (cw.fetch && !flags.noacc) |=> (pc_r == PC_DISPATCH))
    else $error("accepted transaction did not reach dispatch");
  assert property (@(posedge clk) disable iff (!rst_n)
    (cw.op == OP_EMIT && flags.busy) |=> (cw.op == OP_EMIT))
    else $error("emit step left while output busy");
  assert property (@(posedge clk) disable iff (!rst_n)
    (cw.op == OP_START || cw.op == OP_DESC) |=> (cw.op == OP_ANGLE))
    else $error("start or descent step not followed by angle step");

endmodule

>>> src/apogee_brake_p_controller.sv
// top level of the airbrake apogee controller: registers, datapath and output register
// A start transaction arms the controller and returns kind 0 with zero level and
// angle; a control tick, once update_period ms have passed, retracts in descent or
// drives the deploy level from the apogee error in coast, with deadband and step limit.
// Control runs from a small program table that steps one control word per cycle and
// holds at the emit step while out_valid is high and out_ready low, so the item time
// is set by the program path and by the wait for out_ready. A new transaction is
// taken while an earlier result still sits in the output register.
module apogee_brake_p_controller (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [23:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_func,
  input  logic [31:0] in_now_ms,
  input  logic [1:0]  in_phase,
  input  logic signed [31:0] in_apogee_est,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_kind,
  output logic [16:0] out_deploy_level,
  output logic [14:0] out_brake_angle,
  output logic        out_active
);
  import apbc_pkg::*;

  apbc_cw_t    cw;
  apbc_flags_t flags;

  logic [23:0] target_r;
  logic [15:0] gain_r;
  logic [15:0] deadband_r;
  logic [16:0] max_step_r;
  logic [14:0] max_angle_r;
  logic [15:0] period_r;

  logic        func_r;
  logic [31:0] now_r;
  logic [1:0]  phase_r;
  logic [31:0] est_r;

  logic [16:0] level_r;
  logic [16:0] level_nxt;
  logic        active_r;
  logic [31:0] last_r;

  logic signed [32:0] err_r;
  logic signed [32:0] err_nxt;
  logic [46:0] prod_r;
  logic [14:0] ang_r;

  logic        out_valid_r;
  logic        out_kind_r;
  logic [16:0] out_level_r;
  logic [14:0] out_ang_r;
  logic        out_active_r;

  logic        acc;
  logic        busy;
  logic        emit_load;
  logic [31:0] elapsed;
  logic signed [33:0] err_w;
  logic signed [33:0] db_s;
  logic        err_pos;
  logic [30:0] mop;
  logic [38:0] p_sh;
  logic [16:0] cmd;
  logic signed [18:0] delta;
  logic signed [18:0] ms_s;
  logic signed [18:0] lvl_s;
  logic signed [18:0] new_s;
  logic [31:0] aprod;

  apbc_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .flags (flags),
    .cw    (cw)
  );

  assign in_ready  = cw.fetch;
  assign acc       = in_valid && in_ready;
  assign busy      = out_valid_r && !out_ready;
  assign emit_load = (cw.op == OP_EMIT) && !busy;

  assign elapsed = now_r - last_r;
  assign err_w   = {err_r[32], err_r};
  assign db_s    = $signed({18'd0, deadband_r});
  assign err_nxt = $signed({est_r[31], est_r}) - $signed({9'd0, target_r});
  assign err_pos = !err_r[32] && (err_r != '0);
  assign mop     = err_pos ? err_r[30:0] : '0;

  always_comb begin
    flags.noacc   = !acc;
    flags.start   = (func_r == FUNC_START);
    flags.skip    = !active_r || (elapsed < {16'd0, period_r});
    flags.desc    = (phase_r == PHASE_DESCENT);
    flags.nocoast = (phase_r != PHASE_COAST);
    flags.dband   = (err_w > -db_s) && (err_w < db_s);
    flags.busy    = busy;
  end

  // command clamp and step limit
  always_comb begin
    p_sh  = prod_r[46:8];
    cmd   = (p_sh > {22'd0, LEVEL_ONE}) ? LEVEL_ONE : p_sh[16:0];
    lvl_s = $signed({2'b00, level_r});
    ms_s  = $signed({2'b00, max_step_r});
    delta = $signed({2'b00, cmd}) - lvl_s;
    if (delta > ms_s) begin
      new_s = lvl_s + ms_s;
    end else if (delta < -ms_s) begin
      new_s = lvl_s - ms_s;
    end else begin
      new_s = $signed({2'b00, cmd});
    end
    level_nxt = new_s[16:0];
  end

  assign aprod = {15'd0, level_r} * {17'd0, max_angle_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r    <= 24'd780288;
      gain_r      <= 16'd1024;
      deadband_r  <= 16'd1280;
      max_step_r  <= 17'd3277;
      max_angle_r <= 15'd23040;
      period_r    <= 16'd20;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_TARGET_ALT:    target_r    <= cfg_wdata;
        REG_GAIN:          gain_r      <= cfg_wdata[15:0];
        REG_DEADBAND:      deadband_r  <= cfg_wdata[15:0];
        REG_MAX_STEP:      max_step_r  <= cfg_wdata[16:0];
        REG_MAX_ANGLE:     max_angle_r <= cfg_wdata[14:0];
        REG_UPDATE_PERIOD: period_r    <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      func_r  <= in_func;
      now_r   <= in_now_ms;
      phase_r <= in_phase;
      est_r   <= in_apogee_est;
    end
    case (cw.op)
      OP_TAKE:  err_r  <= err_nxt;
      OP_MUL:   prod_r <= {31'd0, gain_r} * {16'd0, mop};
      OP_ANGLE: ang_r  <= aprod[30:16];
      default: ;
    endcase
    if (emit_load) begin
      out_kind_r   <= func_r;
      out_level_r  <= level_r;
      out_ang_r    <= ang_r;
      out_active_r <= active_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r     <= '0;
      active_r    <= 1'b0;
      last_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      case (cw.op)
        OP_START: begin
          level_r  <= '0;
          active_r <= 1'b1;
          last_r   <= now_r;
        end
        OP_TAKE:  last_r <= now_r;
        OP_DESC: begin
          level_r  <= '0;
          active_r <= 1'b0;
        end
        OP_CLAMP: level_r <= level_nxt;
        default: ;
      endcase
      if (emit_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = out_kind_r;
  assign out_deploy_level = out_level_r;
  assign out_brake_angle  = out_ang_r;
  assign out_active       = out_active_r;

  assert property (@(posedge clk) disable iff (!rst_n) level_r <= LEVEL_ONE)
    else $error("deploy level above full");
  assert property (@(posedge clk) disable iff (!rst_n)
    (cw.op == OP_DESC) |=> (!active_r && level_r == '0))
    else $error("descent did not retract");
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(cw.op == OP_EMIT))
    else $error("result raised outside emit step");
  assert property (@(posedge clk) disable iff (!rst_n)
    (cw.op == OP_CLAMP) |=> (cw.op == OP_ANGLE))
    else $error("level update not followed by angle step");

endmodule

>>> tb/sv/apbc_command_checker.sv
// command checker for the airbrake apogee controller: predicts each command and compares output
`timescale 1ns / 1ps
module apbc_command_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_addr,
  input  logic [23:0]        cfg_wdata,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic               in_func,
  input  logic [31:0]        in_now_ms,
  input  logic [1:0]         in_phase,
  input  logic signed [31:0] in_apogee_est,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic               out_kind,
  input  logic [16:0]        out_deploy_level,
  input  logic [14:0]        out_brake_angle,
  input  logic               out_active,
  output int                 mismatch_count,
  output int                 outstanding
);
  import apbc_pkg::*;

  localparam logic KIND_START = 1'b0;
  localparam logic KIND_CMD   = 1'b1;

  typedef struct packed {
    logic        kind;
    logic [16:0] level;
    logic [14:0] angle;
    logic        active;
  } brake_cmd_t;

  logic [23:0] target_alt_r;
  logic [15:0] gain_r;
  logic [15:0] deadband_r;
  logic [16:0] max_step_r;
  logic [14:0] max_angle_r;
  logic [15:0] update_period_r;

  logic [16:0] level_r;
  logic        armed_r;
  logic [31:0] last_ms_r;

  brake_cmd_t pending_cmds [$];

  function automatic brake_cmd_t command_for(input logic kind, input logic [16:0] lvl,
                                             input logic act);
    brake_cmd_t c;
    logic [31:0] prod;
    prod     = {15'd0, lvl} * {17'd0, max_angle_r};
    c.kind   = kind;
    c.level  = lvl;
    c.angle  = prod[30:16];
    c.active = act;
    return c;
  endfunction

  function automatic bit predict_command(input logic func, input logic [31:0] now,
                                         input logic [1:0] ph, input logic [31:0] est_raw,
                                         output brake_cmd_t cmd);
    longint err;
    longint drive;
    longint delta;
    logic [31:0] since;
    cmd = '0;
    if (func == FUNC_START) begin
      armed_r   = 1'b1;
      level_r   = '0;
      last_ms_r = now;
      cmd = command_for(KIND_START, '0, 1'b1);
      return 1'b1;
    end
    if (!armed_r) return 1'b0;
    since = now - last_ms_r;
    if (since < {16'd0, update_period_r}) return 1'b0;
    last_ms_r = now;
    if (ph == PHASE_DESCENT) begin
      armed_r = 1'b0;
      level_r = '0;
      cmd = command_for(KIND_CMD, '0, 1'b0);
      return 1'b1;
    end
    if (ph != PHASE_COAST) return 1'b0;
    err = longint'($signed(est_raw)) - longint'(target_alt_r);
    if (err > -longint'(deadband_r) && err < longint'(deadband_r)) begin
      cmd = command_for(KIND_CMD, level_r, 1'b1);
      return 1'b1;
    end
    if (err <= 0) begin
      drive = 0;
    end else begin
      drive = (longint'(gain_r) * err) >>> 8;
      if (drive > longint'(LEVEL_ONE)) drive = longint'(LEVEL_ONE);
    end
    delta = drive - longint'(level_r);
    if (delta > longint'(max_step_r)) delta = longint'(max_step_r);
    if (delta < -longint'(max_step_r)) delta = -longint'(max_step_r);
    level_r = 17'(longint'(level_r) + delta);
    cmd = command_for(KIND_CMD, level_r, 1'b1);
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    brake_cmd_t predicted;
    brake_cmd_t oldest;
    if (!rst_n) begin
      target_alt_r    = 24'd780288;
      gain_r          = 16'd1024;
      deadband_r      = 16'd1280;
      max_step_r      = 17'd3277;
      max_angle_r     = 15'd23040;
      update_period_r = 16'd20;
      level_r         = '0;
      armed_r         = 1'b0;
      last_ms_r       = '0;
      pending_cmds.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_TARGET_ALT:    target_alt_r    = cfg_wdata;
          REG_GAIN:          gain_r          = cfg_wdata[15:0];
          REG_DEADBAND:      deadband_r      = cfg_wdata[15:0];
          REG_MAX_STEP:      max_step_r      = cfg_wdata[16:0];
          REG_MAX_ANGLE:     max_angle_r     = cfg_wdata[14:0];
          REG_UPDATE_PERIOD: update_period_r = cfg_wdata[15:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        if (predict_command(in_func, in_now_ms, in_phase, in_apogee_est, predicted))
          pending_cmds.push_back(predicted);
      end
      if (out_valid && out_ready) begin
        if (pending_cmds.size() == 0) begin
          $error("unexpected command transaction: kind %0d level %0d angle %0d active %0d",
                 out_kind, out_deploy_level, out_brake_angle, out_active);
          mismatch_count++;
        end else begin
          oldest = pending_cmds.pop_front();
          if (out_kind !== oldest.kind) begin
            $error("kind: expected %0d, got %0d", oldest.kind, out_kind);
            mismatch_count++;
          end
          if (out_deploy_level !== oldest.level) begin
            $error("deploy_level: expected %0d, got %0d", oldest.level, out_deploy_level);
            mismatch_count++;
          end
          if (out_brake_angle !== oldest.angle) begin
            $error("brake_angle: expected %0d, got %0d", oldest.angle, out_brake_angle);
            mismatch_count++;
          end
          if (out_active !== oldest.active) begin
            $error("active: expected %0d, got %0d", oldest.active, out_active);
            mismatch_count++;
          end
        end
      end
    end
    outstanding = pending_cmds.size();
  end

endmodule

>>> tb/sv/tb_apogee_brake_p_controller.sv
// testbench top for the airbrake apogee controller: clock, reset, stimulus and verdict
`timescale 1ns / 1ps
module tb_apogee_brake_p_controller;
  import apbc_pkg::*;

  localparam logic       FUNC_TICK   = 1'b1;
  localparam logic [1:0] PHASE_OTHER = 2'd0;
  localparam logic [1:0] PHASE_SPARE = 2'd3;
  localparam logic [2:0] REG_SPARE_A = 3'd6;
  localparam logic [2:0] REG_SPARE_B = 3'd7;
  localparam int         HOLD_CYCLES = 300;

  logic               clk;
  logic               rst_n;
  logic               cfg_we;
  logic [2:0]         cfg_addr;
  logic [23:0]        cfg_wdata;
  logic               in_valid;
  logic               in_ready;
  logic               in_func;
  logic [31:0]        in_now_ms;
  logic [1:0]         in_phase;
  logic signed [31:0] in_apogee_est;
  logic               out_valid;
  logic               out_ready;
  logic               out_kind;
  logic [16:0]        out_deploy_level;
  logic [14:0]        out_brake_angle;
  logic               out_active;

  int          mismatch_count;
  int          outstanding;
  int          items_sent;
  int          cur_target;
  int          cur_deadband;
  int          cur_period;
  logic [31:0] flight_ms;
  bit          hold_req;
  bit          calm;

  apogee_brake_p_controller DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_addr         (cfg_addr),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_func          (in_func),
    .in_now_ms        (in_now_ms),
    .in_phase         (in_phase),
    .in_apogee_est    (in_apogee_est),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_kind         (out_kind),
    .out_deploy_level (out_deploy_level),
    .out_brake_angle  (out_brake_angle),
    .out_active       (out_active)
  );

  apbc_command_checker cmd_check (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_addr         (cfg_addr),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_func          (in_func),
    .in_now_ms        (in_now_ms),
    .in_phase         (in_phase),
    .in_apogee_est    (in_apogee_est),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_kind         (out_kind),
    .out_deploy_level (out_deploy_level),
    .out_brake_angle  (out_brake_angle),
    .out_active       (out_active),
    .mismatch_count   (mismatch_count),
    .outstanding      (outstanding)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  initial begin
    #2_000_000;
    $display("apogee_brake_p_controller verification failed");
    $finish;
  end

  // receiver: random back-pressure bursts, quiet stretches and one long hold
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
        out_ready <= 1'b1;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 4)) @(negedge clk);
        out_ready <= 1'b1;
      end else if ($urandom_range(0, 30) == 0) begin
        out_ready <= 1'b1;
        repeat ($urandom_range(20, 60)) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic send_item(input logic func, input logic [31:0] now, input logic [1:0] ph,
                           input logic [31:0] est);
    if (!calm && !hold_req && $urandom_range(0, 4) == 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat ($urandom_range(0, 3)) @(negedge clk);
    end
    @(negedge clk);
    in_valid      <= 1'b1;
    in_func       <= func;
    in_now_ms     <= now;
    in_phase      <= ph;
    in_apogee_est <= est;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (16) @(negedge clk);
  endtask

  task automatic write_settings(input logic [23:0] tgt, input logic [23:0] kp,
                                input logic [23:0] db, input logic [23:0] stp,
                                input logic [23:0] ang, input logic [23:0] per);
    logic [23:0] vals [8];
    vals[REG_TARGET_ALT]    = tgt;
    vals[REG_GAIN]          = kp;
    vals[REG_DEADBAND]      = db;
    vals[REG_MAX_STEP]      = stp;
    vals[REG_MAX_ANGLE]     = ang;
    vals[REG_UPDATE_PERIOD] = per;
    vals[REG_SPARE_A]       = 24'($urandom);
    vals[REG_SPARE_B]       = 24'($urandom);
    for (int i = 0; i < 8; i++) begin
      @(negedge clk);
      cfg_we    <= 1'b1;
      cfg_addr  <= 3'(i);
      cfg_wdata <= vals[i];
    end
    @(negedge clk);
    cfg_we <= 1'b0;
    cur_target   = int'(tgt);
    cur_deadband = int'(db[15:0]);
    cur_period   = int'(per[15:0]);
  endtask

  // one armed flight: an optional tick, then start, then mostly coast ticks until descent or the tick budget
  task automatic fly(input int ticks);
    int          r;
    int          span;
    int          dt;
    logic [1:0]  ph;
    logic [31:0] est;
    longint      off;
    if ($urandom_range(0, 3) == 0)
      flight_ms = 32'hFFFF_FFFF - 32'($urandom_range(0, cur_period * 2 + 100));
    else
      flight_ms = $urandom;
    if ($urandom_range(0, 4) == 0)
      send_item(FUNC_TICK, $urandom, 2'($urandom), $urandom);
    send_item(FUNC_START, flight_ms, 2'($urandom), $urandom);
    for (int k = 0; k < ticks; k++) begin
      r = $urandom_range(0, 99);
      if (r < 10 && cur_period > 0)
        dt = $urandom_range(0, cur_period - 1);
      else
        dt = cur_period + $urandom_range(0, 40);
      flight_ms = flight_ms + 32'(dt);
      r = $urandom_range(0, 99);
      if (r < 84)      ph = PHASE_COAST;
      else if (r < 89) ph = PHASE_OTHER;
      else if (r < 94) ph = PHASE_SPARE;
      else             ph = PHASE_DESCENT;
      r = $urandom_range(0, 99);
      span = cur_deadband * 2 + 64;
      off = 0;
      if (r < 45)
        off = longint'($urandom_range(0, 2 * span)) - span;
      else if (r < 85)
        off = longint'($urandom_range(0, 1 << 18)) - (1 << 17);
      if (r < 85)
        est = 32'(longint'(cur_target) + off);
      else
        est = $urandom;
      send_item(FUNC_TICK, flight_ms, ph, est);
      if (ph == PHASE_DESCENT) break;
    end
  endtask

  task automatic run_flights(input int count);
    int goal;
    goal = items_sent + count;
    while (items_sent < goal) fly($urandom_range(8, 40));
  endtask

  initial begin
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_addr      = REG_TARGET_ALT;
    cfg_wdata     = '0;
    in_valid      = 1'b0;
    in_func       = FUNC_TICK;
    in_now_ms     = '0;
    in_phase      = PHASE_OTHER;
    in_apogee_est = '0;
    hold_req      = 1'b0;
    calm          = 1'b0;
    items_sent    = 0;
    cur_target    = 780288;
    cur_deadband  = 1280;
    cur_period    = 20;
    flight_ms     = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed, reset settings
    send_item(FUNC_TICK, 32'd5, PHASE_COAST, 32'(cur_target + 50000));
    send_item(FUNC_START, 32'd1000, PHASE_OTHER, '0);
    send_item(FUNC_TICK, 32'd1019, PHASE_COAST, 32'(cur_target + 50000));
    send_item(FUNC_TICK, 32'd1020, PHASE_OTHER, 32'(cur_target + 50000));
    send_item(FUNC_TICK, 32'd1040, PHASE_SPARE, 32'(cur_target + 50000));
    send_item(FUNC_TICK, 32'd1060, PHASE_COAST, 32'(cur_target + 100));
    send_item(FUNC_TICK, 32'd1080, PHASE_COAST, 32'(cur_target + 1280));
    send_item(FUNC_TICK, 32'd1100, PHASE_COAST, 32'(cur_target - 1279));
    send_item(FUNC_TICK, 32'd1120, PHASE_COAST, 32'(cur_target - 1280));
    send_item(FUNC_TICK, 32'd1140, PHASE_COAST, 32'h7FFF_FFFF);
    send_item(FUNC_TICK, 32'd1160, PHASE_COAST, 32'h7FFF_FFFF);
    send_item(FUNC_TICK, 32'd1180, PHASE_COAST, 32'h8000_0000);
    send_item(FUNC_TICK, 32'd1200, PHASE_COAST, 32'hFFFF_FFFF);
    send_item(FUNC_START, 32'd1210, PHASE_COAST, 32'h7FFF_FFFF);
    send_item(FUNC_TICK, 32'd1230, PHASE_COAST, 32'h7FFF_FFFF);
    send_item(FUNC_TICK, 32'd1250, PHASE_DESCENT, '0);
    send_item(FUNC_TICK, 32'd1300, PHASE_COAST, 32'h7FFF_FFFF);
    send_item(FUNC_START, 32'hFFFF_FFF0, PHASE_DESCENT, 32'hFFFF_FFFF);
    send_item(FUNC_TICK, 32'h0000_0003, PHASE_COAST, 32'(cur_target + 20000));
    send_item(FUNC_TICK, 32'h0000_0004, PHASE_COAST, 32'(cur_target + 20000));

    // long output hold while the sender keeps going
    hold_req = 1'b1;
    flight_ms = 32'd50_000;
    send_item(FUNC_START, flight_ms, PHASE_OTHER, '0);
    repeat (30) begin
      flight_ms = flight_ms + 32'd20;
      send_item(FUNC_TICK, flight_ms, PHASE_COAST,
                32'(cur_target + $urandom_range(0, 40000)));
    end
    run_flights(110);

    settle();
    write_settings(24'd0, 24'd65535, 24'd0, 24'd65536, 24'd23040, 24'd0);
    run_flights(100);

    settle();
    write_settings(24'hFF_FFFF, 24'd0, 24'd65535, 24'd0, 24'd0, 24'd65535);
    run_flights(40);

    settle();
    write_settings(24'($urandom), 24'($urandom), 24'($urandom_range(0, 2000)), 24'hFF_FFFF,
                   24'h00_7FFF, 24'($urandom_range(0, 100)));
    run_flights(80);

    settle();
    write_settings(24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom),
                   24'($urandom), 24'($urandom));
    run_flights(80);

    settle();
    write_settings(24'($urandom_range(0, 24'hFF_FFFF)), 24'($urandom_range(1, 8000)),
                   24'($urandom_range(1, 3000)), 24'($urandom_range(1, 65536)),
                   24'($urandom_range(0, 23040)), 24'($urandom_range(1, 200)));
    run_flights(60);

    settle();
    calm = 1'b1;
    write_settings(24'd780288, 24'd1024, 24'd1280, 24'd3277, 24'd23040, 24'd20);
    run_flights(90);

    settle();
    if (mismatch_count == 0) begin
      $display("apogee_brake_p_controller verification clean");
    end else begin
      $display("apogee_brake_p_controller verification failed");
    end
    $finish;
  end

endmodule

>>> sim.f
src/apbc_pkg.sv
src/apbc_seq.sv
src/apogee_brake_p_controller.sv
tb/sv/apbc_command_checker.sv
tb/sv/tb_apogee_brake_p_controller.sv
